>>> sv/awd_pkg.sv
`default_nettype none

package awd_pkg;

    // Default configuration of the lookup tables and fixed-point format
    localparam int SEGMENTS_DEF = 64;
    localparam int FRAC_DEF     = 12;

    // Slope register reset value
    localparam logic [14:0] ALPHA_RESET = 15'd410;

    // Register index bit of paddr (byte address 4*i)
    localparam logic ADDR_ALPHA = 1'b0;

    // Activation modes
    localparam logic [2:0] MODE_RELU    = 3'd0;
    localparam logic [2:0] MODE_LEAKY   = 3'd1;
    localparam logic [2:0] MODE_SIGMOID = 3'd2;
    localparam logic [2:0] MODE_TANH    = 3'd3;
    localparam logic [2:0] MODE_SILU    = 3'd4;
    localparam logic [2:0] MODE_ELU     = 3'd5;

    // One in Q30
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // Request payload
    typedef struct packed {
        logic [2:0]          mode;
        logic signed [15:0]  x_in;
        logic                track_gradient;
    } sample_t;

    // Result payload
    typedef struct packed {
        logic signed [15:0]  y_out;
        logic signed [15:0]  dydx;
        logic                grad_valid;
    } result_t;

    // Table read stage
    typedef struct packed {
        sample_t             tag;
        logic [30:0]         lo;
        logic signed [31:0]  dlt;
        logic [14:0]         frac;
        logic                flip;
    } lkp_t;

    // Interpolated sigmoid or exp value, Q30
    typedef struct packed {
        sample_t             tag;
        logic [30:0]         v;
    } itp_t;

    // After first product
    typedef struct packed {
        sample_t             tag;
        logic [30:0]         v;
        logic signed [63:0]  p1;
    } mul1_t;

    // After second product
    typedef struct packed {
        sample_t             tag;
        logic [30:0]         v;
        logic signed [63:0]  p1;
        logic signed [31:0]  w;
        logic signed [63:0]  p2;
    } mul2_t;

    // After third product
    typedef struct packed {
        sample_t             tag;
        logic [30:0]         v;
        logic signed [63:0]  p1;
        logic signed [31:0]  w;
        logic signed [63:0]  p2;
        logic signed [63:0]  p3;
    } mul3_t;

    // Saturate to 16 bits signed
    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767)
            r = 16'sh7fff;
        else if (v < -64'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // Round half up at the shift, then saturate
    function automatic logic signed [15:0] round_sat(input logic signed [63:0] v,
                                                     input int s);
        logic signed [63:0] r;
        r = (v + (64'sd1 <<< (s - 1))) >>> s;
        return sat16(r);
    endfunction

    // Unsigned quotient by shift and subtract; only used for the constant tables
    function automatic longint unsigned const_quot(input longint unsigned n,
                                                   input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], n[i]};
            if (r >= d)
            begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-a) in Q30: Taylor series on a reduced argument, then repeated squaring
    function automatic longint unsigned exp_neg_q30(input longint unsigned a30,
                                                    input int frac);
        longint unsigned b;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        int              halvings;
        halvings = 16 - frac;
        b        = a30 >> halvings;
        term     = 64'd1 << 30;
        sum      = 64'sd1 <<< 30;
        for (int i = 1; i <= 16; i++)
        begin
            term = const_quot((term * b) >> 30, 64'(i));
            if (i[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > (64'sd1 <<< 30))
            sum = 64'sd1 <<< 30;
        v = longint'(sum);
        for (int i = 0; i < halvings; i++)
        begin
            v = (v * v + (64'd1 << 29)) >> 30;
        end
        return v;
    endfunction

    // Table point k: sigmoid(-a_k) or exp(-a_k), Q30
    function automatic logic [30:0] tab_entry(input logic is_sig, input int k,
                                              input int seg, input int frac);
        longint unsigned a30;
        longint unsigned e;
        longint unsigned den;
        longint unsigned s;
        a30 = const_quot(longint'(k) << (45 - frac), 64'(seg));
        e   = exp_neg_q30(a30, frac);
        den = (64'd1 << 30) + e;
        s   = const_quot((e << 30) + (den >> 1), den);
        return is_sig ? s[30:0] : e[30:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/awd_interp.sv
`default_nettype none

module awd_interp
    import awd_pkg::*;
#(
    parameter int TABLE_SEGMENTS = SEGMENTS_DEF,
    parameter int FRAC_BITS      = FRAC_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    adv,
    input  wire logic    in_vld,
    input  wire sample_t in_data,
    output logic         itp_vld,
    output itp_t         itp_data
);

    localparam int KW = $clog2(TABLE_SEGMENTS + 1);
    localparam int PW = 17 + KW;

    // Constant tables, evaluated at elaboration
    logic [30:0] sig_tab [TABLE_SEGMENTS + 1];
    logic [30:0] exp_tab [TABLE_SEGMENTS + 1];

    for (genvar i = 0; i <= TABLE_SEGMENTS; i++)
    begin : g_tab
        localparam logic [30:0] SIG_PT = tab_entry(1'b1, i, TABLE_SEGMENTS, FRAC_BITS);
        localparam logic [30:0] EXP_PT = tab_entry(1'b0, i, TABLE_SEGMENTS, FRAC_BITS);
        assign sig_tab[i] = SIG_PT;
        assign exp_tab[i] = EXP_PT;
    end

    logic               lkp_vld_reg;
    lkp_t               lkp_reg;
    lkp_t               lkp_next;
    logic               itp_vld_reg;
    itp_t               itp_reg;
    itp_t               itp_next;

    logic signed [17:0] xs;
    logic signed [17:0] x2;
    logic [16:0]        mag_x;
    logic [16:0]        mag_2x;
    logic [16:0]        t;
    logic [PW-1:0]      p;
    logic [KW-1:0]      k;
    logic [KW-1:0]      k1;
    logic [30:0]        lo;
    logic [30:0]        hi;
    logic               pos;

    // Table address and neighbouring points
    always_comb
    begin
        xs     = 18'(in_data.x_in);
        x2     = xs <<< 1;
        mag_x  = xs[17] ? 17'(-xs) : xs[16:0];
        mag_2x = x2[17] ? 17'(-x2) : x2[16:0];
        pos    = !in_data.x_in[15] && (in_data.x_in != 16'sd0);
        case (in_data.mode)
            MODE_TANH: t = (mag_2x > 17'd32768) ? 17'd32768 : mag_2x;
            default:   t = mag_x;
        endcase
        p  = PW'(t) * PW'(TABLE_SEGMENTS);
        k  = p[15 +: KW];
        k1 = (k == KW'(TABLE_SEGMENTS)) ? k : k + 1'b1;
        if (in_data.mode == MODE_ELU)
        begin
            lo = exp_tab[k];
            hi = exp_tab[k1];
        end
        else
        begin
            lo = sig_tab[k];
            hi = sig_tab[k1];
        end
        lkp_next.tag  = in_data;
        lkp_next.lo   = lo;
        lkp_next.dlt  = $signed({1'b0, hi}) - $signed({1'b0, lo});
        lkp_next.frac = p[14:0];
        lkp_next.flip = pos;
    end

    // Linear interpolation; positive argument takes the complement
    logic signed [47:0] acc;
    logic [30:0]        lval;

    always_comb
    begin
        acc = $signed({2'b00, lkp_reg.lo, 15'd0})
            + 48'(lkp_reg.dlt) * 48'($signed({1'b0, lkp_reg.frac}))
            + 48'sd16384;
        lval = acc[45:15];
        itp_next.tag = lkp_reg.tag;
        itp_next.v   = lkp_reg.flip ? (Q30_ONE - lval) : lval;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lkp_vld_reg <= 1'b0;
            itp_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            lkp_vld_reg <= in_vld;
            itp_vld_reg <= lkp_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lkp_reg <= lkp_next;
            itp_reg <= itp_next;
        end
    end

    assign itp_vld  = itp_vld_reg;
    assign itp_data = itp_reg;

endmodule

`default_nettype wire

>>> sv/awd_mult.sv
`default_nettype none

module awd_mult
    import awd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        adv,
    input  wire logic [14:0] alpha,
    input  wire logic        itp_vld,
    input  wire itp_t        itp_data,
    output logic             m3_vld,
    output mul3_t            m3_data
);

    logic  m1_vld_reg;
    logic  m2_vld_reg;
    logic  m3_vld_reg;
    mul1_t m1_reg;
    mul1_t m1_next;
    mul2_t m2_reg;
    mul2_t m2_next;
    mul3_t m3_reg;
    mul3_t m3_next;

    logic signed [31:0] sv;
    logic signed [31:0] th;
    logic signed [31:0] opa;
    logic signed [31:0] opb;
    logic signed [31:0] alpha_s;
    logic signed [31:0] x1;

    // First product, operands chosen by mode
    always_comb
    begin
        sv      = $signed({1'b0, itp_data.v});
        th      = (sv <<< 1) - 32'sh4000_0000;
        alpha_s = $signed({17'd0, alpha});
        x1      = 32'(itp_data.tag.x_in);
        case (itp_data.tag.mode)
            MODE_SIGMOID, MODE_SILU:
            begin
                opa = sv;
                opb = 32'sh4000_0000 - sv;
            end
            MODE_TANH:
            begin
                opa = th;
                opb = th;
            end
            MODE_LEAKY:
            begin
                opa = alpha_s;
                opb = x1;
            end
            MODE_ELU:
            begin
                opa = alpha_s;
                opb = sv;
            end
            default:
            begin
                opa = 32'sd0;
                opb = 32'sd0;
            end
        endcase
        m1_next.tag = itp_data.tag;
        m1_next.v   = itp_data.v;
        m1_next.p1  = 64'(opa) * 64'(opb);
    end

    logic signed [63:0] r1;
    logic signed [31:0] x2;

    // Rounded Q30 product and x*s
    always_comb
    begin
        r1 = (m1_reg.p1 + 64'sd536870912) >>> 30;
        x2 = 32'(m1_reg.tag.x_in);
        m2_next.tag = m1_reg.tag;
        m2_next.v   = m1_reg.v;
        m2_next.p1  = m1_reg.p1;
        if (m1_reg.tag.mode == MODE_TANH)
            m2_next.w = 32'sh4000_0000 - 32'(r1);
        else
            m2_next.w = 32'(r1);
        m2_next.p2 = 64'(x2) * 64'($signed({1'b0, m1_reg.v}));
    end

    logic signed [31:0] x3;

    // x times w (the sigmoid slope for sigmoid and SiLU)
    always_comb
    begin
        x3 = 32'(m2_reg.tag.x_in);
        m3_next.tag = m2_reg.tag;
        m3_next.v   = m2_reg.v;
        m3_next.p1  = m2_reg.p1;
        m3_next.w   = m2_reg.w;
        m3_next.p2  = m2_reg.p2;
        m3_next.p3  = 64'(x3) * 64'(m2_reg.w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_vld_reg <= itp_vld;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg <= m1_next;
            m2_reg <= m2_next;
            m3_reg <= m3_next;
        end
    end

    assign m3_vld  = m3_vld_reg;
    assign m3_data = m3_reg;

endmodule

`default_nettype wire

>>> sv/awd_format.sv
`default_nettype none

module awd_format
    import awd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        adv,
    input  wire logic [14:0] alpha,
    input  wire logic        m3_vld,
    input  wire mul3_t       m3_data,
    output logic             out_vld,
    output result_t          out_data
);

    localparam int                 OS     = 30 - FRAC_BITS;
    localparam logic signed [63:0] HALF_F = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [15:0] ONE_OUT =
        (FRAC_BITS >= 15) ? 16'sh7fff : 16'(1 << FRAC_BITS);

    logic    out_vld_reg;
    result_t out_reg;
    result_t out_next;

    logic signed [63:0] v64;
    logic signed [63:0] w64;
    logic signed [63:0] a64;
    logic signed [15:0] y;
    logic signed [15:0] g;
    logic               pos;

    // Final rounding and saturation per mode
    always_comb
    begin
        v64 = 64'($signed({1'b0, m3_data.v}));
        w64 = 64'(m3_data.w);
        a64 = 64'($signed({1'b0, alpha}));
        pos = !m3_data.tag.x_in[15] && (m3_data.tag.x_in != 16'sd0);
        case (m3_data.tag.mode)
            MODE_RELU:
            begin
                y = pos ? m3_data.tag.x_in : 16'sd0;
                g = pos ? ONE_OUT : 16'sd0;
            end
            MODE_LEAKY:
            begin
                y = pos ? m3_data.tag.x_in : round_sat(m3_data.p1, FRAC_BITS);
                g = pos ? ONE_OUT : $signed({1'b0, alpha});
            end
            MODE_SIGMOID:
            begin
                y = round_sat(v64, OS);
                g = round_sat(w64, OS);
            end
            MODE_TANH:
            begin
                y = round_sat((v64 <<< 1) - 64'sh4000_0000, OS);
                g = round_sat(w64, OS);
            end
            MODE_SILU:
            begin
                y = round_sat(m3_data.p2, 30);
                g = round_sat(v64 + ((m3_data.p3 + HALF_F) >>> FRAC_BITS), OS);
            end
            MODE_ELU:
            begin
                y = pos ? m3_data.tag.x_in : sat16(w64 - a64);
                g = pos ? ONE_OUT : sat16(w64);
            end
            default:
            begin
                y = 16'sd0;
                g = 16'sd0;
            end
        endcase
        out_next.y_out      = y;
        out_next.dydx       = m3_data.tag.track_gradient ? g : 16'sd0;
        out_next.grad_valid = m3_data.tag.track_gradient;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= m3_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out_vld  = out_vld_reg;
    assign out_data = out_reg;

endmodule

`default_nettype wire

>>> sv/activation_with_derivative.sv
// Throughput: one request per cycle unless stalled; six register stages (table read,
// interpolation, three multiplier stages, output rounding) advance together and hold
// while stalled. Reset clears every stage valid bit and loads alpha_reg with 410;
// the lookup tables are constants and need no initialisation.
`default_nettype none

module activation_with_derivative
    import awd_pkg::*;
#(
    parameter int TABLE_SEGMENTS = SEGMENTS_DEF,
    parameter int FRAC_BITS      = FRAC_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        sample_valid,
    output logic             sample_stall,
    input  wire sample_t     sample,
    output logic             result_valid,
    input  wire logic        result_stall,
    output result_t          result
);

    logic [14:0] alpha_reg;
    logic [14:0] alpha_next;
    logic        wr_en;
    logic        adv;
    logic        itp_vld;
    itp_t        itp_data;
    logic        m3_vld;
    mul3_t       m3_data;

    // Register port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == ADDR_ALPHA);
    assign prdata = (paddr[2] == ADDR_ALPHA) ? {17'd0, alpha_reg} : 32'd0;

    always_comb
    begin
        alpha_next = wr_en ? pwdata[14:0] : alpha_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alpha_reg <= ALPHA_RESET;
        else
            alpha_reg <= alpha_next;
    end

    // Whole pipe moves unless a finished result is held
    assign adv          = !(result_valid && result_stall);
    assign sample_stall = !adv;

    awd_interp #(
        .TABLE_SEGMENTS (TABLE_SEGMENTS),
        .FRAC_BITS      (FRAC_BITS)
    ) u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (sample_valid),
        .in_data  (sample),
        .itp_vld  (itp_vld),
        .itp_data (itp_data)
    );

    awd_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .alpha    (alpha_reg),
        .itp_vld  (itp_vld),
        .itp_data (itp_data),
        .m3_vld   (m3_vld),
        .m3_data  (m3_data)
    );

    awd_format #(
        .FRAC_BITS (FRAC_BITS)
    ) u_format (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .alpha    (alpha_reg),
        .m3_vld   (m3_vld),
        .m3_data  (m3_data),
        .out_vld  (result_valid),
        .out_data (result)
    );

`ifndef SYNTHESIS
    // An untracked result carries no derivative
    a_grad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.grad_valid |-> result.dydx == 16'sd0)
        else $error("derivative set without grad_valid");

    // A held result blocks new requests
    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> sample_stall)
        else $error("request accepted while result held");

    // Slope changes only on a register write
    a_alpha_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(psel && penable && pwrite) |=> $stable(alpha_reg))
        else $error("slope register changed without a write");
`endif

endmodule

`default_nettype wire

>>> sim/activation_with_derivative_tb.sv
`timescale 1ns / 1ps

module activation_with_derivative_tb;
    import awd_pkg::*;

    localparam int SEG  = 64;
    localparam int FRAC = 12;
    localparam longint ONE_Q30 = 64'sd1 <<< 30;
    // Mode codes with no activation behind them
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        sample_valid;
    logic        sample_stall;
    sample_t     sample;
    logic        result_valid;
    logic        result_stall;
    result_t     result;

    activation_with_derivative u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Predictor state
    longint      exp_pts[0:SEG];
    longint      sig_pts[0:SEG];
    longint      alpha_shadow;
    result_t     pending_results[$];
    int          mismatch_count;
    bit          hold_receiver;
    int          stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    // exp(-a) in Q30 from a reduced Taylor series, squared back up
    function automatic longint exp_neg(input longint unsigned a30);
        longint unsigned b;
        longint unsigned term;
        longint unsigned v;
        longint          acc;
        b    = a30 >> (16 - FRAC);
        term = 64'd1 << 30;
        acc  = ONE_Q30;
        for (int i = 1; i <= 16; i++)
        begin
            term = ((term * b) >> 30) / longint'(i);
            if (i % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > ONE_Q30)
            acc = ONE_Q30;
        v = acc;
        for (int i = 0; i < 16 - FRAC; i++)
            v = (v * v + (64'd1 << 29)) >> 30;
        return longint'(v);
    endfunction

    function automatic longint clamp16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Round half up at the shift (arithmetic shift floors)
    function automatic longint rnd(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint q30_to_out(input longint v);
        return clamp16(rnd(v, 30 - FRAC));
    endfunction

    // Linear interpolation over a table at magnitude t
    function automatic longint interp(input bit use_exp, input longint t);
        longint p;
        longint k;
        longint f;
        longint lo;
        longint hi;
        if (t < 0)
            t = 0;
        if (t > 32768)
            t = 32768;
        p = t * SEG;
        k = p >>> 15;
        f = p & 32767;
        if (k >= SEG)
            return use_exp ? exp_pts[SEG] : sig_pts[SEG];
        lo = use_exp ? exp_pts[k] : sig_pts[k];
        hi = use_exp ? exp_pts[k + 1] : sig_pts[k + 1];
        return (lo * (32768 - f) + hi * f + 16384) >>> 15;
    endfunction

    function automatic longint sigmoid30(input longint x);
        if (x <= 0)
            return interp(1'b0, -x);
        return ONE_Q30 - interp(1'b0, x);
    endfunction

    function automatic result_t activate(input sample_t s);
        result_t r;
        longint  x;
        longint  y;
        longint  g;
        longint  sg;
        longint  th;
        longint  q;
        longint  e;
        x = longint'(s.x_in);
        y = 0;
        g = 0;
        case (s.mode)
            MODE_RELU:
            begin
                y = x > 0 ? x : 0;
                g = x > 0 ? q30_to_out(ONE_Q30) : 0;
            end
            MODE_LEAKY:
            begin
                y = x > 0 ? x : clamp16(rnd(alpha_shadow * x, FRAC));
                g = x > 0 ? q30_to_out(ONE_Q30) : alpha_shadow;
            end
            MODE_SIGMOID:
            begin
                sg = sigmoid30(x);
                y  = q30_to_out(sg);
                g  = q30_to_out((sg * (ONE_Q30 - sg) + (64'sd1 <<< 29)) >>> 30);
            end
            MODE_TANH:
            begin
                sg = sigmoid30(2 * x);
                th = 2 * sg - ONE_Q30;
                y  = q30_to_out(th);
                g  = q30_to_out(ONE_Q30 - ((th * th + (64'sd1 <<< 29)) >>> 30));
            end
            MODE_SILU:
            begin
                sg = sigmoid30(x);
                q  = (sg * (ONE_Q30 - sg) + (64'sd1 <<< 29)) >>> 30;
                y  = clamp16(rnd(x * sg, 30));
                g  = q30_to_out(sg + rnd(x * q, FRAC));
            end
            MODE_ELU:
            begin
                if (x > 0)
                begin
                    y = x;
                    g = q30_to_out(ONE_Q30);
                end
                else
                begin
                    e = interp(1'b1, -x);
                    y = clamp16(rnd(alpha_shadow * (e - ONE_Q30), 30));
                    g = clamp16(rnd(alpha_shadow * e, 30));
                end
            end
            default:
            begin
                y = 0;
                g = 0;
            end
        endcase
        r.y_out      = y[15:0];
        r.dydx       = s.track_gradient ? g[15:0] : 16'sd0;
        r.grad_valid = s.track_gradient;
        return r;
    endfunction

    // Offer one request, hold it until taken, then log its expected result
    task automatic offer(input sample_t s, input result_t expected);
        sample       <= s;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        pending_results.insert(pending_results.size(), expected);
    endtask

    task automatic idle_gap(input int n);
        sample_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_alpha(input logic [14:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {1'b0, ADDR_ALPHA, 1'b0} & 3'b000;
        pwdata  <= {17'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        alpha_shadow = longint'(v);
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        int      pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            s.mode = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
        else
            s.mode = 3'($urandom_range(0, 5));
        pick = $urandom_range(0, 9);
        if (pick < 4)
            s.x_in = 16'($urandom_range(0, 65535));
        else if (pick < 9)
            s.x_in = 16'($signed($urandom_range(0, 16384)) - 8192);
        else
            s.x_in = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        s.track_gradient = $urandom_range(0, 3) != 0;
        return s;
    endfunction

    // Random stretch in bursts with gaps; optional long receiver hold / full drain
    task automatic random_run(input int count, input bit with_hold, input bit with_pause);
        sample_t s;
        int      burst;
        burst = $urandom_range(1, 20);
        for (int i = 0; i < count; i++)
        begin
            if (with_hold && i == count / 4)
                hold_receiver = 1'b1;
            if (with_pause && i == count / 2)
            begin
                sample_valid <= 1'b0;
                drain();
            end
            s = random_sample();
            offer(s, activate(s));
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 2) != 0)
                    idle_gap($urandom_range(1, 8));
            end
        end
        sample_valid <= 1'b0;
    endtask

    // Receiver: stall pattern that shifts density, with an occasional long hold
    initial
    begin
        result_stall = 1'b0;
        stall_pct    = 0;
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
            begin
                result_stall <= 1'b1;
                repeat (40) @(posedge clk);
                hold_receiver = 1'b0;
            end
            if ($urandom_range(0, 199) == 0)
                stall_pct = $urandom_range(0, 2) * 35;
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result y=%0d g=%0d gv=%0b",
                             result.y_out, result.dydx, result.grad_valid);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result.y_out !== exp_r.y_out || result.dydx !== exp_r.dydx
                    || result.grad_valid !== exp_r.grad_valid)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp y=%0d g=%0d gv=%0b got y=%0d g=%0d gv=%0b",
                                 exp_r.y_out, exp_r.dydx, exp_r.grad_valid,
                                 result.y_out, result.dydx, result.grad_valid);
                end
            end
        end
    end

    typedef struct {
        logic [2:0]         mode;
        logic signed [15:0] x;
        logic               trk;
        bit                 typed;
        logic signed [15:0] y;
        logic signed [15:0] g;
    } dir_row_t;

    initial
    begin
        dir_row_t dir_rows[23];
        sample_t  s;
        result_t  r;

        dir_rows = '{
            '{MODE_RELU,    16'sd0,      1'b1, 1'b1, 16'sd0,     16'sd0},
            '{MODE_RELU,    16'sh7fff,   1'b1, 1'b1, 16'sh7fff,  16'sd4096},
            '{MODE_RELU,    16'sh8000,   1'b1, 1'b1, 16'sd0,     16'sd0},
            '{MODE_RELU,    16'sd1,      1'b1, 1'b1, 16'sd1,     16'sd4096},
            '{MODE_LEAKY,   16'sd0,      1'b1, 1'b1, 16'sd0,     16'sd410},
            '{MODE_LEAKY,   16'sh7fff,   1'b1, 1'b1, 16'sh7fff,  16'sd4096},
            '{MODE_LEAKY,   16'sh8000,   1'b1, 1'b0, 16'sd0,     16'sd0},
            '{MODE_LEAKY,   16'sd4096,   1'b0, 1'b1, 16'sd4096,  16'sd0},
            '{MODE_SIGMOID, 16'sd0,      1'b1, 1'b0, 16'sd0,     16'sd0},
            '{MODE_SIGMOID, 16'sh7fff,   1'b1, 1'b0, 16'sd0,     16'sd0},
            '{MODE_SIGMOID, 16'sh8000,   1'b1, 1'b0, 16'sd0,     16'sd0},
            '{MODE_TANH,    16'sd0,      1'b1, 1'b0, 16'sd0,     16'sd0},
            '{MODE_TANH,    16'sh7fff,   1'b1, 1'b0, 16'sd0,     16'sd0},
            '{MODE_TANH,    16'sh8000,   1'b1, 1'b0, 16'sd0,     16'sd0},
            '{MODE_TANH,    16'sd16384,  1'b1, 1'b0, 16'sd0,     16'sd0},
            '{MODE_SILU,    16'sd0,      1'b1, 1'b0, 16'sd0,     16'sd0},
            '{MODE_SILU,    16'sh8000,   1'b1, 1'b0, 16'sd0,     16'sd0},
            '{MODE_SILU,    16'sh7fff,   1'b1, 1'b0, 16'sd0,     16'sd0},
            '{MODE_ELU,     16'sd0,      1'b1, 1'b1, 16'sd0,     16'sd410},
            '{MODE_ELU,     16'sh8000,   1'b1, 1'b0, 16'sd0,     16'sd0},
            '{MODE_ELU,     16'sh7fff,   1'b1, 1'b0, 16'sd0,     16'sd0},
            '{MODE_SPARE_A, -16'sd100,   1'b1, 1'b1, 16'sd0,     16'sd0},
            '{MODE_SPARE_B, 16'sd5,      1'b0, 1'b1, 16'sd0,     16'sd0}
        };

        // Known levels on every input from time zero
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        sample_valid   = 1'b0;
        sample         = '0;
        hold_receiver  = 1'b0;
        mismatch_count = 0;
        alpha_shadow   = 410;

        // Interpolation tables
        for (int k = 0; k <= SEG; k++)
        begin
            longint unsigned a30;
            longint e;
            longint den;
            a30 = (longint'(k) << (45 - FRAC)) / SEG;
            e   = exp_neg(a30);
            den = ONE_Q30 + e;
            exp_pts[k] = e;
            sig_pts[k] = (e * ONE_Q30 + den / 2) / den;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at reset alpha
        foreach (dir_rows[i])
        begin
            s.mode           = dir_rows[i].mode;
            s.x_in           = dir_rows[i].x;
            s.track_gradient = dir_rows[i].trk;
            if (dir_rows[i].typed)
            begin
                r.y_out      = dir_rows[i].y;
                r.dydx       = dir_rows[i].g;
                r.grad_valid = dir_rows[i].trk;
            end
            else
                r = activate(s);
            offer(s, r);
        end
        sample_valid <= 1'b0;

        random_run(300, 1'b0, 1'b0);
        drain();
        write_alpha(15'd0);
        random_run(250, 1'b0, 1'b0);
        drain();
        write_alpha(15'h7fff);
        random_run(250, 1'b1, 1'b0);
        drain();
        write_alpha(15'($urandom_range(0, 32767)));
        random_run(300, 1'b0, 1'b1);
        drain();

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
